[sv/crt_pkg.sv]
// package for the crt residue combiner: widths, status codes, sequencer states
// no dependencies
package crt_pkg;
  localparam int MW = 16;
  localparam int PW = 64;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_COPRIME = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_ZERO_MOD = 2'd3;
  typedef enum logic [4:0] {
    S_IDLE, S_RMOD, S_EUC_CHK, S_EUC_DIV, S_EUC_MUL, S_EUC_MOD, S_OVF_LO, S_OVF_HI,
    S_OVF_CHK, S_XMOD, S_SMOD, S_TMUL, S_TMOD, S_UPD_LO, S_UPD_HI, S_UPD_ADD, S_OUT
  } state_t;
endpackage

[sv/crt_residue_combiner_unit.sv]
// top level of the crt residue combiner: sequencer, euclid registers, multiplier
// depends on crt_pkg and crt_divider
//
// Input channel s_axis: tdata = {residue, modulus, first_pair} from bit 0 up,
// one pair per transaction. Output channel m_axis: one result per pair with
// tdata = {solution, product_modulus, status} from bit 0 up.
// Each pair runs on one shared 64-bit restoring divider (per division: launch,
// a shift per quotient bit, then done) and one 32x32 multiplier.
// From acceptance to m_axis_tvalid a merge runs one reduction of the running
// modulus, then k Euclid steps (k is 1 for modulus one, up to about 24 for 16-bit
// moduli), each a division, a multiply and a reduction, then three reductions
// with multiplies around them.
// A pair held off by a sticky error or a zero modulus answers in the cycle after acceptance.
// The block takes one pair at a time: s_axis_tready is low from acceptance until
// the result has been taken. The result is held in place while m_axis_tready is
// low. Reset sets the running modulus to one, the running solution and the error
// code to zero, and drops m_axis_tvalid.
// A first_pair flag restarts the set; an error code is sticky until then.
module crt_residue_combiner_unit import crt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // residue, modulus, first_pair, zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata   // solution, product_modulus, status, zero pad
);
  state_t state, state_next;
  logic [PW-1:0] rmod, rsol;
  logic [1:0] err;
  logic [MW-1:0] x, m;
  logic [MW-1:0] r0, r1, c0, c1, q, inv, d, t;
  logic [2*MW-1:0] pq;
  logic [PW-1:0] plo, phi, pm;
  logic [PW:0] ovf_sum;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic div_wait, div_start, div_done;
  logic [PW-1:0] dvd, dsr, dq, drem;

  crt_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dvd), .divisor(dsr),
    .done(div_done), .quotient(dq), .remainder(drem)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {6'd0, err, rmod, rsol};
  assign prod = {32'd0, ma} * {32'd0, mb};
  // running modulus times m fits when high partial plus carry stays in 32 bits
  assign ovf_sum = {1'b0, phi} + {33'd0, plo[63:32]};

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    dvd = '0;
    dsr = PW'(m);
    ma = '0;
    mb = '0;
    unique case (state)
      S_IDLE: if (s_axis_tvalid) begin
        if (!s_axis_tdata[32] && err != ST_OK) state_next = S_OUT;
        else if (s_axis_tdata[31:16] == '0) state_next = S_OUT;
        else state_next = S_RMOD;
      end
      S_RMOD: begin
        dvd = rmod;
        div_start = !div_wait;
        if (div_done) state_next = S_EUC_CHK;
      end
      S_EUC_CHK: begin
        if (r1 != '0) state_next = S_EUC_DIV;
        else if (r0 != MW'(1)) state_next = S_OUT;
        else state_next = S_OVF_LO;
      end
      S_EUC_DIV: begin
        dvd = PW'(r0);
        dsr = PW'(r1);
        div_start = !div_wait;
        if (div_done) state_next = S_EUC_MUL;
      end
      S_EUC_MUL: begin
        ma = 32'(q);
        mb = 32'(c1);
        state_next = S_EUC_MOD;
      end
      S_EUC_MOD: begin
        dvd = PW'(pq);
        div_start = !div_wait;
        if (div_done) state_next = S_EUC_CHK;
      end
      S_OVF_LO: begin
        ma = rmod[31:0];
        mb = 32'(m);
        state_next = S_OVF_HI;
      end
      S_OVF_HI: begin
        ma = rmod[63:32];
        mb = 32'(m);
        state_next = S_OVF_CHK;
      end
      S_OVF_CHK: begin
        if (ovf_sum[PW:32] != '0) state_next = S_OUT;
        else state_next = S_XMOD;
      end
      S_XMOD: begin
        dvd = PW'(x);
        div_start = !div_wait;
        if (div_done) state_next = S_SMOD;
      end
      S_SMOD: begin
        dvd = rsol;
        div_start = !div_wait;
        if (div_done) state_next = S_TMUL;
      end
      S_TMUL: begin
        ma = 32'(d);
        mb = 32'(inv);
        state_next = S_TMOD;
      end
      S_TMOD: begin
        dvd = PW'(pq);
        div_start = !div_wait;
        if (div_done) state_next = S_UPD_LO;
      end
      S_UPD_LO: begin
        ma = rmod[31:0];
        mb = 32'(t);
        state_next = S_UPD_HI;
      end
      S_UPD_HI: begin
        ma = rmod[63:32];
        mb = 32'(t);
        state_next = S_UPD_ADD;
      end
      S_UPD_ADD: state_next = S_OUT;
      S_OUT: if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // one launch per division state, then wait for done
  always_ff @(posedge clk) begin
    if (rst) div_wait <= 1'b0;
    else if (div_start) div_wait <= 1'b1;
    else if (div_done) div_wait <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rmod <= PW'(1);
      rsol <= '0;
      err <= ST_OK;
    end else begin
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          if (s_axis_tdata[32]) begin
            rmod <= PW'(1);
            rsol <= '0;
          end
          if (s_axis_tdata[32] || err == ST_OK) begin
            if (s_axis_tdata[31:16] == '0) err <= ST_ZERO_MOD;
            else err <= ST_OK;
          end
        end
        S_EUC_CHK: if (r1 == '0 && r0 != MW'(1)) err <= ST_NOT_COPRIME;
        S_OVF_CHK: if (ovf_sum[PW:32] != '0) err <= ST_OVERFLOW;
        S_UPD_ADD: begin
          rsol <= rsol + plo + {phi[31:0], 32'd0};
          rmod <= pm;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (s_axis_tvalid) begin
        x <= s_axis_tdata[15:0];
        m <= s_axis_tdata[31:16];
      end
      S_RMOD: if (div_done) begin
        r0 <= drem[MW-1:0];
        r1 <= m;
        c0 <= (m == MW'(1)) ? '0 : MW'(1);
        c1 <= '0;
      end
      S_EUC_CHK: inv <= c0;
      S_EUC_DIV: if (div_done) begin
        // the quotient never exceeds m, so reducing it is a compare
        q <= (dq[MW-1:0] == m) ? '0 : dq[MW-1:0];
        r0 <= r1;
        r1 <= drem[MW-1:0];
      end
      S_EUC_MUL: pq <= prod[2*MW-1:0];
      S_EUC_MOD: if (div_done) begin
        c0 <= c1;
        c1 <= (c0 >= drem[MW-1:0]) ? c0 - drem[MW-1:0] : c0 + (m - drem[MW-1:0]);
      end
      S_OVF_LO: plo <= prod;
      S_OVF_HI: phi <= prod;
      S_OVF_CHK: pm <= {ovf_sum[31:0], plo[31:0]};
      S_XMOD: if (div_done) x <= drem[MW-1:0];
      S_SMOD: if (div_done) begin
        d <= (x >= drem[MW-1:0]) ? x - drem[MW-1:0] : x + (m - drem[MW-1:0]);
      end
      S_TMUL: pq <= prod[2*MW-1:0];
      S_TMOD: if (div_done) t <= drem[MW-1:0];
      S_UPD_LO: plo <= prod;
      S_UPD_HI: phi <= prod;
      default: ;
    endcase
  end
endmodule

[sv/crt_divider.sv]
// shared restoring divider, one quotient bit per cycle
// uses crt_pkg for the product width
module crt_divider import crt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PW-1:0] dividend,
  input  logic [PW-1:0] divisor,
  output logic          done,
  output logic [PW-1:0] quotient,
  output logic [PW-1:0] remainder
);
  logic [PW-1:0] rem, quo, dsr;
  logic [6:0] count;
  logic busy;
  logic [PW:0] shifted;
  logic [PW:0] diff;

  assign shifted = {rem, quo[PW-1]};
  assign diff = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 7'(PW);
      end else if (busy) begin
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!diff[PW]) begin
        rem <= diff[PW-1:0];
        quo <= {quo[PW-2:0], 1'b1};
      end else begin
        rem <= shifted[PW-1:0];
        quo <= {quo[PW-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;
  assign remainder = rem;
endmodule
